// File: rtl/core/i2cbs_pkg.sv
// Shared types, command codes and phase codes for the I2C bit sequencer.
package i2cbs_pkg;

    localparam int TICK_COUNTER_BITS = 16;
    localparam int PHASE_BITS        = 3;
    localparam int CFG_BITS          = 16;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;
    localparam logic [2:0] CMD_CHECK = 3'd5;
    localparam logic [2:0] CMD_ACK   = 3'd6;
    localparam logic [2:0] CMD_NACK  = 3'd7;

    localparam logic [PHASE_BITS-1:0] PH_IDLE = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_1    = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_2    = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_3    = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_4    = 3'd4;
    localparam logic [PHASE_BITS-1:0] PH_5    = 3'd5;

    localparam logic [3:0] BITS_BYTE = 4'd8;
    localparam logic [3:0] BITS_ONE  = 4'd1;
    localparam logic [7:0] ACK_BYTE  = 8'h00;
    localparam logic [7:0] NACK_BYTE = 8'h80;

    localparam logic [CFG_BITS-1:0] PHASE_TICKS_RESET = 16'd13;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data_byte;
        logic       sda_in;
    } t_in_word;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       ack_ok;
    } t_out_word;

    typedef struct packed {
        logic [TICK_COUNTER_BITS-1:0] tick_count;
        logic [PHASE_BITS-1:0]        phase_step;
        logic [2:0]                   active_command;
        logic [3:0]                   bit_index;
        logic [7:0]                   shift_byte;
        logic                         scl_reg;
        logic                         sda_reg;
        logic                         sda_drive_reg;
        logic [7:0]                   read_reg;
        logic                         ack_reg;
    } t_seq_state;

endpackage

// File: rtl/core/i2c_master_bit_sequencer.sv
// I2C master bit sequencer top level: input register, step logic, output register.
//
// Every input word is one tick of bus time and gives exactly one result word.
// A word is taken every clock unless a stall on the result side holds it off;
// it is held in the input register, the step logic updates the sequencer state
// and the result is caught in the output register, where it stays on the output
// until it is taken. Stall on the result side holds the output register and
// then the input register. The phase_ticks register (reset 13, zero acts as
// one) sets how many ticks lie between consecutive SCL/SDA actions; write it
// only while no command runs.
module i2c_master_bit_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  i2cbs_pkg::t_in_word                 i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output i2cbs_pkg::t_out_word                o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [i2cbs_pkg::CFG_BITS-1:0]      i_cfg_data
);

    logic                           r_in_valid;
    i2cbs_pkg::t_in_word            r_in;
    logic                           r_out_valid;
    i2cbs_pkg::t_out_word           r_out;
    i2cbs_pkg::t_seq_state          r_state;
    logic [i2cbs_pkg::CFG_BITS-1:0] r_phase_ticks;

    i2cbs_pkg::t_seq_state          n_state;
    i2cbs_pkg::t_out_word           n_out;
    logic                           advance;
    logic                           accept_in;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign accept_in   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    i2cbs_step u_step (
        .i_state       (r_state),
        .i_word        (r_in),
        .i_phase_ticks (r_phase_ticks),
        .o_state       (n_state),
        .o_word        (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid                  <= 1'b0;
            r_out_valid                 <= 1'b0;
            r_phase_ticks               <= i2cbs_pkg::PHASE_TICKS_RESET;
            r_state.tick_count          <= '0;
            r_state.phase_step          <= i2cbs_pkg::PH_IDLE;
            r_state.active_command      <= i2cbs_pkg::CMD_NONE;
            r_state.bit_index           <= 4'd0;
            r_state.shift_byte          <= 8'h00;
            r_state.scl_reg             <= 1'b1;
            r_state.sda_reg             <= 1'b1;
            r_state.sda_drive_reg       <= 1'b0;
            r_state.read_reg            <= 8'h00;
            r_state.ack_reg             <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_phase_ticks <= i_cfg_data;
            end
            if (accept_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

// File: rtl/core/i2cbs_step.sv
// Next-state and result logic for one tick of the bit sequencer.
module i2cbs_step (
    input  i2cbs_pkg::t_seq_state                   i_state,
    input  i2cbs_pkg::t_in_word                     i_word,
    input  logic [i2cbs_pkg::CFG_BITS-1:0]          i_phase_ticks,
    output i2cbs_pkg::t_seq_state                   o_state,
    output i2cbs_pkg::t_out_word                    o_word
);

    // One bus action at the given phase; phase_step of the result is the next phase.
    function automatic i2cbs_pkg::t_seq_state act(
        input i2cbs_pkg::t_seq_state                s_i,
        input logic [i2cbs_pkg::PHASE_BITS-1:0]     step_i,
        input logic                                 sda_i
    );
        i2cbs_pkg::t_seq_state            s;
        logic [i2cbs_pkg::PHASE_BITS-1:0] st;
        logic                             fin;
        s   = s_i;
        st  = step_i;
        fin = 1'b0;
        s.phase_step = i2cbs_pkg::PH_IDLE;
        case (s.active_command)
            i2cbs_pkg::CMD_START: begin
                if (st == i2cbs_pkg::PH_1) begin
                    s.sda_drive_reg = 1'b1;
                    s.sda_reg       = 1'b1;
                    s.scl_reg       = 1'b1;
                    s.phase_step    = i2cbs_pkg::PH_2;
                end else if (st == i2cbs_pkg::PH_2) begin
                    s.sda_drive_reg = 1'b1;
                    s.sda_reg       = 1'b0;
                    s.phase_step    = i2cbs_pkg::PH_3;
                end else if (st == i2cbs_pkg::PH_3) begin
                    s.scl_reg    = 1'b0;
                    s.phase_step = i2cbs_pkg::PH_4;
                end
            end
            i2cbs_pkg::CMD_STOP: begin
                if (st == i2cbs_pkg::PH_1) begin
                    s.sda_drive_reg = 1'b1;
                    s.sda_reg       = 1'b0;
                    s.phase_step    = i2cbs_pkg::PH_2;
                end else if (st == i2cbs_pkg::PH_2) begin
                    s.scl_reg    = 1'b1;
                    s.phase_step = i2cbs_pkg::PH_3;
                end else if (st == i2cbs_pkg::PH_3) begin
                    s.sda_drive_reg = 1'b1;
                    s.sda_reg       = 1'b1;
                    s.phase_step    = i2cbs_pkg::PH_4;
                end
            end
            i2cbs_pkg::CMD_WRITE, i2cbs_pkg::CMD_ACK, i2cbs_pkg::CMD_NACK: begin
                // end of a bit: count it, then either finish or start the next one
                if (st == i2cbs_pkg::PH_4) begin
                    s.bit_index = s.bit_index - 4'd1;
                    if (s.bit_index == 4'd0) begin
                        fin = 1'b1;
                    end else begin
                        st = i2cbs_pkg::PH_1;
                    end
                end
                if (!fin) begin
                    if (st == i2cbs_pkg::PH_1) begin
                        s.sda_drive_reg = 1'b1;
                        s.sda_reg       = s.shift_byte[7];
                        s.shift_byte    = {s.shift_byte[6:0], 1'b0};
                        s.phase_step    = i2cbs_pkg::PH_2;
                    end else if (st == i2cbs_pkg::PH_2) begin
                        s.scl_reg    = 1'b1;
                        s.phase_step = i2cbs_pkg::PH_3;
                    end else if (st == i2cbs_pkg::PH_3) begin
                        s.scl_reg    = 1'b0;
                        s.phase_step = i2cbs_pkg::PH_4;
                    end
                end
            end
            i2cbs_pkg::CMD_READ: begin
                if (st == i2cbs_pkg::PH_1) begin
                    s.sda_drive_reg = 1'b0;
                    s.scl_reg       = 1'b0;
                    s.phase_step    = i2cbs_pkg::PH_2;
                end else if (st == i2cbs_pkg::PH_2) begin
                    s.scl_reg    = 1'b1;
                    s.phase_step = i2cbs_pkg::PH_3;
                end else if (st == i2cbs_pkg::PH_3) begin
                    s.shift_byte = {s.shift_byte[6:0], sda_i};
                    s.scl_reg    = 1'b0;
                    s.bit_index  = s.bit_index - 4'd1;
                    if (s.bit_index != 4'd0) begin
                        s.phase_step = i2cbs_pkg::PH_2;
                    end else begin
                        s.read_reg = s.shift_byte;
                    end
                end
            end
            i2cbs_pkg::CMD_CHECK: begin
                if (st == i2cbs_pkg::PH_1) begin
                    s.sda_drive_reg = 1'b0;
                    s.phase_step    = i2cbs_pkg::PH_2;
                end else if (st == i2cbs_pkg::PH_2) begin
                    s.scl_reg    = 1'b1;
                    s.phase_step = i2cbs_pkg::PH_3;
                end else if (st == i2cbs_pkg::PH_3) begin
                    s.ack_reg    = ~sda_i;
                    s.phase_step = i2cbs_pkg::PH_4;
                end else if (st == i2cbs_pkg::PH_4) begin
                    s.scl_reg    = 1'b0;
                    s.phase_step = i2cbs_pkg::PH_5;
                end
            end
            default: begin
                s.phase_step = i2cbs_pkg::PH_IDLE;
            end
        endcase
        return s;
    endfunction

    logic [i2cbs_pkg::TICK_COUNTER_BITS-1:0] limit;
    logic [i2cbs_pkg::TICK_COUNTER_BITS-1:0] cnt;
    i2cbs_pkg::t_seq_state                   s_load;
    i2cbs_pkg::t_seq_state                   s_next;
    logic                                    fired;
    logic                                    done;

    // a zero period behaves as one tick
    assign limit = (i_phase_ticks == '0) ? i2cbs_pkg::TICK_COUNTER_BITS'(1)
                                         : i2cbs_pkg::TICK_COUNTER_BITS'(i_phase_ticks);
    assign cnt   = i_state.tick_count + i2cbs_pkg::TICK_COUNTER_BITS'(1);

    always_comb begin
        s_load = i_state;
        s_next = i_state;
        fired  = 1'b0;
        done   = 1'b0;
        if (i_state.phase_step != i2cbs_pkg::PH_IDLE) begin
            if (cnt >= limit) begin
                s_load.tick_count = '0;
                s_next = act(s_load, i_state.phase_step, i_word.sda_in);
                fired  = 1'b1;
            end else begin
                s_next.tick_count = cnt;
            end
        end else if (i_word.func != i2cbs_pkg::CMD_NONE) begin
            s_load.active_command = i_word.func;
            s_load.tick_count     = '0;
            s_load.bit_index      = i2cbs_pkg::BITS_BYTE;
            s_load.shift_byte     = 8'h00;
            if (i_word.func == i2cbs_pkg::CMD_WRITE) begin
                s_load.shift_byte = i_word.data_byte;
            end
            if (i_word.func == i2cbs_pkg::CMD_ACK) begin
                s_load.bit_index  = i2cbs_pkg::BITS_ONE;
                s_load.shift_byte = i2cbs_pkg::ACK_BYTE;
            end
            if (i_word.func == i2cbs_pkg::CMD_NACK) begin
                s_load.bit_index  = i2cbs_pkg::BITS_ONE;
                s_load.shift_byte = i2cbs_pkg::NACK_BYTE;
            end
            s_next = act(s_load, i2cbs_pkg::PH_1, i_word.sda_in);
            fired  = 1'b1;
        end
        if (fired && s_next.phase_step == i2cbs_pkg::PH_IDLE) begin
            done                  = 1'b1;
            s_next.active_command = i2cbs_pkg::CMD_NONE;
        end
    end

    assign o_state = s_next;

    always_comb begin
        o_word.scl_level = s_next.scl_reg;
        o_word.sda_level = s_next.sda_reg;
        o_word.sda_drive = s_next.sda_drive_reg;
        o_word.busy_res  = (s_next.phase_step != i2cbs_pkg::PH_IDLE);
        o_word.done_res  = done;
        o_word.read_data = s_next.read_reg;
        o_word.ack_ok    = s_next.ack_reg;
    end

endmodule

// File: test/tb_top.sv
// Testbench for the I2C master bit sequencer: random bus ticks against a tick-level predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int QUIET_LIMIT = 2000;
    localparam int IDLE_PCT    = 28;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    i2cbs_pkg::t_in_word            in_word;
    logic                           out_valid;
    logic                           out_stall;
    i2cbs_pkg::t_out_word           out_word;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [i2cbs_pkg::CFG_BITS-1:0] cfg_data;

    i2c_master_bit_sequencer i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // two copies of the sequencer: one steers stimulus, one predicts results
    i2cbs_pkg::t_seq_state          plan_state;
    i2cbs_pkg::t_seq_state          live_state;
    logic [i2cbs_pkg::CFG_BITS-1:0] phase_ticks_reg;

    i2cbs_pkg::t_in_word  tick_queue[$];
    i2cbs_pkg::t_out_word expected_levels[$];

    bit                   in_fire        = 1'b0;
    bit                   calm;
    int                   quiet_cycles   = 0;
    int                   mismatch_count = 0;
    int                   results_seen   = 0;
    int                   pushed_ticks;
    i2cbs_pkg::t_out_word want_word;

    function automatic i2cbs_pkg::t_seq_state idle_bus_state();
        i2cbs_pkg::t_seq_state s;
        s         = '0;
        s.scl_reg = 1'b1;
        s.sda_reg = 1'b1;
        return s;
    endfunction

    // one SCL/SDA action at the current step; leaves the next step in phase_step
    function automatic void bus_action(inout i2cbs_pkg::t_seq_state s, input logic sda);
        logic [i2cbs_pkg::PHASE_BITS-1:0] stp;
        stp          = s.phase_step;
        s.phase_step = i2cbs_pkg::PH_IDLE;
        case (s.active_command)
            i2cbs_pkg::CMD_START: begin
                if (stp == i2cbs_pkg::PH_1) begin
                    s.sda_drive_reg = 1'b1;
                    s.sda_reg       = 1'b1;
                    s.scl_reg       = 1'b1;
                    s.phase_step    = i2cbs_pkg::PH_2;
                end else if (stp == i2cbs_pkg::PH_2) begin
                    s.sda_drive_reg = 1'b1;
                    s.sda_reg       = 1'b0;
                    s.phase_step    = i2cbs_pkg::PH_3;
                end else if (stp == i2cbs_pkg::PH_3) begin
                    s.scl_reg    = 1'b0;
                    s.phase_step = i2cbs_pkg::PH_4;
                end
            end
            i2cbs_pkg::CMD_STOP: begin
                if (stp == i2cbs_pkg::PH_1) begin
                    s.sda_drive_reg = 1'b1;
                    s.sda_reg       = 1'b0;
                    s.phase_step    = i2cbs_pkg::PH_2;
                end else if (stp == i2cbs_pkg::PH_2) begin
                    s.scl_reg    = 1'b1;
                    s.phase_step = i2cbs_pkg::PH_3;
                end else if (stp == i2cbs_pkg::PH_3) begin
                    s.sda_drive_reg = 1'b1;
                    s.sda_reg       = 1'b1;
                    s.phase_step    = i2cbs_pkg::PH_4;
                end
            end
            i2cbs_pkg::CMD_WRITE, i2cbs_pkg::CMD_ACK, i2cbs_pkg::CMD_NACK: begin
                // end of a bit: go round for the next one or finish
                if (stp == i2cbs_pkg::PH_4) begin
                    s.bit_index = s.bit_index - 4'd1;
                    stp = (s.bit_index == 4'd0) ? i2cbs_pkg::PH_IDLE : i2cbs_pkg::PH_1;
                end
                if (stp == i2cbs_pkg::PH_1) begin
                    s.sda_drive_reg = 1'b1;
                    s.sda_reg       = s.shift_byte[7];
                    s.shift_byte    = {s.shift_byte[6:0], 1'b0};
                    s.phase_step    = i2cbs_pkg::PH_2;
                end else if (stp == i2cbs_pkg::PH_2) begin
                    s.scl_reg    = 1'b1;
                    s.phase_step = i2cbs_pkg::PH_3;
                end else if (stp == i2cbs_pkg::PH_3) begin
                    s.scl_reg    = 1'b0;
                    s.phase_step = i2cbs_pkg::PH_4;
                end
            end
            i2cbs_pkg::CMD_READ: begin
                if (stp == i2cbs_pkg::PH_1) begin
                    s.sda_drive_reg = 1'b0;
                    s.scl_reg       = 1'b0;
                    s.phase_step    = i2cbs_pkg::PH_2;
                end else if (stp == i2cbs_pkg::PH_2) begin
                    s.scl_reg    = 1'b1;
                    s.phase_step = i2cbs_pkg::PH_3;
                end else if (stp == i2cbs_pkg::PH_3) begin
                    s.shift_byte = {s.shift_byte[6:0], sda};
                    s.scl_reg    = 1'b0;
                    s.bit_index  = s.bit_index - 4'd1;
                    if (s.bit_index != 4'd0) begin
                        s.phase_step = i2cbs_pkg::PH_2;
                    end else begin
                        s.read_reg = s.shift_byte;
                    end
                end
            end
            i2cbs_pkg::CMD_CHECK: begin
                if (stp == i2cbs_pkg::PH_1) begin
                    s.sda_drive_reg = 1'b0;
                    s.phase_step    = i2cbs_pkg::PH_2;
                end else if (stp == i2cbs_pkg::PH_2) begin
                    s.scl_reg    = 1'b1;
                    s.phase_step = i2cbs_pkg::PH_3;
                end else if (stp == i2cbs_pkg::PH_3) begin
                    s.ack_reg    = ~sda;
                    s.phase_step = i2cbs_pkg::PH_4;
                end else if (stp == i2cbs_pkg::PH_4) begin
                    s.scl_reg    = 1'b0;
                    s.phase_step = i2cbs_pkg::PH_5;
                end
            end
            default: s.phase_step = i2cbs_pkg::PH_IDLE;
        endcase
    endfunction

    // advance the sequencer by one bus tick and give the bus levels after it
    function automatic i2cbs_pkg::t_out_word bus_tick(inout i2cbs_pkg::t_seq_state s,
                                                      input i2cbs_pkg::t_in_word w,
                                                      input logic [i2cbs_pkg::CFG_BITS-1:0] ticks);
        i2cbs_pkg::t_out_word           r;
        logic                           done;
        logic [i2cbs_pkg::CFG_BITS-1:0] lim;
        done = 1'b0;
        lim  = (ticks == '0) ? i2cbs_pkg::CFG_BITS'(1) : ticks;
        if (s.phase_step != i2cbs_pkg::PH_IDLE) begin
            s.tick_count = s.tick_count + i2cbs_pkg::TICK_COUNTER_BITS'(1);
            if (s.tick_count >= lim) begin
                s.tick_count = '0;
                bus_action(s, w.sda_in);
                if (s.phase_step == i2cbs_pkg::PH_IDLE) begin
                    done             = 1'b1;
                    s.active_command = i2cbs_pkg::CMD_NONE;
                end
            end
        end else if (w.func != i2cbs_pkg::CMD_NONE) begin
            s.active_command = w.func;
            s.tick_count     = '0;
            s.bit_index      = i2cbs_pkg::BITS_BYTE;
            s.shift_byte     = 8'h00;
            if (w.func == i2cbs_pkg::CMD_WRITE) s.shift_byte = w.data_byte;
            if (w.func == i2cbs_pkg::CMD_ACK) begin
                s.bit_index  = i2cbs_pkg::BITS_ONE;
                s.shift_byte = i2cbs_pkg::ACK_BYTE;
            end
            if (w.func == i2cbs_pkg::CMD_NACK) begin
                s.bit_index  = i2cbs_pkg::BITS_ONE;
                s.shift_byte = i2cbs_pkg::NACK_BYTE;
            end
            s.phase_step = i2cbs_pkg::PH_1;
            bus_action(s, w.sda_in);
        end
        r.scl_level = s.scl_reg;
        r.sda_level = s.sda_reg;
        r.sda_drive = s.sda_drive_reg;
        r.busy_res  = (s.phase_step != i2cbs_pkg::PH_IDLE);
        r.done_res  = done;
        r.read_data = s.read_reg;
        r.ack_ok    = s.ack_reg;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        mismatch_count++;
        $display("mismatch on result %0d: %s got %0h want %0h",
                 results_seen, field, got, want);
    endtask

    task automatic check_result(input i2cbs_pkg::t_out_word got,
                                input i2cbs_pkg::t_out_word want);
        if (got.scl_level !== want.scl_level)
            report_mismatch("scl", 8'(got.scl_level), 8'(want.scl_level));
        if (got.sda_level !== want.sda_level)
            report_mismatch("sda", 8'(got.sda_level), 8'(want.sda_level));
        if (got.sda_drive !== want.sda_drive)
            report_mismatch("sda_drive", 8'(got.sda_drive), 8'(want.sda_drive));
        if (got.busy_res !== want.busy_res)
            report_mismatch("busy", 8'(got.busy_res), 8'(want.busy_res));
        if (got.done_res !== want.done_res)
            report_mismatch("done", 8'(got.done_res), 8'(want.done_res));
        if (got.read_data !== want.read_data)
            report_mismatch("read_data", got.read_data, want.read_data);
        if (got.ack_ok !== want.ack_ok)
            report_mismatch("ack_ok", 8'(got.ack_ok), 8'(want.ack_ok));
    endtask

    // monitor: result check first, then predict the word taken on this edge
    always @(posedge clk) begin
        in_fire = 1'b0;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_levels.size() == 0) begin
                    report_mismatch("unexpected word", 8'h00, 8'h00);
                end else begin
                    want_word = expected_levels.pop_front();
                    check_result(out_word, want_word);
                end
                results_seen++;
            end
            if (in_valid && !in_stall) begin
                in_fire = 1'b1;
                expected_levels.push_back(bus_tick(live_state, in_word, phase_ticks_reg));
            end
            if (in_fire || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // driver: new word only once the last one has gone
    always @(negedge clk) begin
        if (in_fire || !in_valid) begin
            if (tick_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                in_word  <= tick_queue.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("status: fail");
        $finish;
    end

    function automatic logic pick_sda(input int mode);
        return (mode < 0) ? logic'($urandom_range(0, 1)) : mode[0];
    endfunction

    task automatic push_tick(input logic [2:0] func, input logic [7:0] data, input logic sda);
        i2cbs_pkg::t_in_word w;
        w.func      = func;
        w.data_byte = data;
        w.sda_in    = sda;
        void'(bus_tick(plan_state, w, phase_ticks_reg));
        tick_queue.push_back(w);
        pushed_ticks++;
    endtask

    // issue a command, then tick with noise on func until it completes
    task automatic plan_command(input logic [2:0] func, input logic [7:0] data, input int sda_mode);
        push_tick(func, data, pick_sda(sda_mode));
        while (plan_state.phase_step != i2cbs_pkg::PH_IDLE)
            push_tick(3'($urandom_range(0, 7)), 8'($urandom), pick_sda(sda_mode));
        repeat ($urandom_range(0, 2)) push_tick(i2cbs_pkg::CMD_NONE, 8'($urandom), 1'($urandom));
    endtask

    task automatic random_transaction();
        if ($urandom_range(0, 99) < 20) begin
            plan_command(3'($urandom_range(1, 7)), 8'($urandom), -1);
        end else begin
            plan_command(i2cbs_pkg::CMD_START, 8'($urandom), -1);
            plan_command(i2cbs_pkg::CMD_WRITE, 8'($urandom), -1);
            plan_command(i2cbs_pkg::CMD_CHECK, 8'($urandom), -1);
            repeat ($urandom_range(0, 2)) begin
                if ($urandom_range(0, 1)) begin
                    plan_command(i2cbs_pkg::CMD_WRITE, 8'($urandom), -1);
                    plan_command(i2cbs_pkg::CMD_CHECK, 8'($urandom), -1);
                end else begin
                    plan_command(i2cbs_pkg::CMD_READ, 8'($urandom), -1);
                    plan_command($urandom_range(0, 1) ? i2cbs_pkg::CMD_ACK : i2cbs_pkg::CMD_NACK,
                                 8'($urandom), -1);
                end
            end
            plan_command(i2cbs_pkg::CMD_STOP, 8'($urandom), -1);
        end
    endtask

    task automatic random_traffic(input int budget);
        int first;
        first = pushed_ticks;
        while (pushed_ticks - first < budget) random_transaction();
    endtask

    task automatic wait_drained();
        while (tick_queue.size() != 0 || in_valid || expected_levels.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_phase_ticks(input logic [i2cbs_pkg::CFG_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        phase_ticks_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        in_word         = '0;
        out_stall       = 1'b0;
        cfg_valid       = 1'b0;
        cfg_data        = '0;
        calm            = 1'b0;
        pushed_ticks    = 0;
        plan_state      = idle_bus_state();
        live_state      = idle_bus_state();
        phase_ticks_reg = i2cbs_pkg::PHASE_TICKS_RESET;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default phase length out of reset
        plan_command(i2cbs_pkg::CMD_START, 8'h00, -1);
        plan_command(i2cbs_pkg::CMD_STOP, 8'h5A, -1);
        wait_drained();

        write_phase_ticks(16'd1);
        push_tick(i2cbs_pkg::CMD_NONE, 8'hFF, 1'b1);
        push_tick(i2cbs_pkg::CMD_NONE, 8'h00, 1'b0);
        plan_command(i2cbs_pkg::CMD_START, 8'h00, -1);
        plan_command(i2cbs_pkg::CMD_WRITE, 8'h00, -1);
        plan_command(i2cbs_pkg::CMD_WRITE, 8'hFF, -1);
        plan_command(i2cbs_pkg::CMD_CHECK, 8'h00, 1);
        plan_command(i2cbs_pkg::CMD_CHECK, 8'h00, 0);
        plan_command(i2cbs_pkg::CMD_READ, 8'h00, 1);
        plan_command(i2cbs_pkg::CMD_READ, 8'hFF, 0);
        plan_command(i2cbs_pkg::CMD_READ, 8'h3C, -1);
        plan_command(i2cbs_pkg::CMD_ACK, 8'hFF, -1);
        plan_command(i2cbs_pkg::CMD_NACK, 8'h00, -1);
        plan_command(i2cbs_pkg::CMD_STOP, 8'hFF, -1);
        random_traffic(40);
        wait_drained();             // sender holds off until the pipe is empty
        random_traffic(40);
        wait_drained();

        // zero acts as one
        write_phase_ticks(16'd0);
        calm = 1'b1;
        random_traffic(40);
        wait_drained();
        calm = 1'b0;

        write_phase_ticks(16'd2);
        random_traffic(40);
        wait_drained();

        repeat (4) @(posedge clk);
        if (expected_levels.size() != 0) report_mismatch("words outstanding", 8'h00, 8'h00);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
